// ===== sv/pva_pkg.sv =====
// Shared constants and types of the polyphonic voice allocator.
package pva_pkg;

	localparam int MAX_VOICES = 8;
	localparam int NUM_NOTES  = 128;
	localparam int VI_W       = 3;
	localparam int NOTE_W     = 7;
	localparam int POS_W      = 8;
	localparam int REL_W      = 16;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ON     = 2'd1;
	localparam logic [1:0] CMD_OFF    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_START   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_END     = 2'd3;

	typedef logic [MAX_VOICES-1:0][NOTE_W-1:0] voice_note_arr_t;
	typedef logic [MAX_VOICES-1:0][POS_W-1:0]  pos_arr_t;

	// request to the press-order stack
	typedef struct packed {
		logic              start;
		logic              is_on;
		logic [NOTE_W-1:0] note;
	} stk_req_t;

	// stack sweep result
	typedef struct packed {
		logic              done;
		logic              heir_found;
		logic [NOTE_W-1:0] heir;
	} stk_res_t;

endpackage

// ===== sv/pva_stack.sv =====
// Press-order stack: memory plus the read-modify-write sweep over all notes.
module pva_stack (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pva_pkg::stk_req_t        req,
	input  pva_pkg::voice_note_arr_t vnote,
	input  logic [pva_pkg::MAX_VOICES-1:0] vhas,
	output pva_pkg::stk_res_t        res,
	output pva_pkg::pos_arr_t        vpos
);
	import pva_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_REF   = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DONE  = 4'b1000
	} st_t;

	st_t               state_q;
	logic              is_on_q;
	logic [NOTE_W-1:0] note_q;
	logic [POS_W-1:0]  ref_q;
	logic [NOTE_W-1:0] idx_q;
	logic [POS_W:0]    best_q;
	logic              heir_found_q;
	logic [NOTE_W-1:0] heir_q;
	pos_arr_t          vpos_q;

	logic [POS_W-1:0]  mem [NUM_NOTES];
	logic [NUM_NOTES-1:0] valid_q;
	logic [POS_W-1:0]  rdata_s1;
	logic              rvld_s1;

	logic              rd_en;
	logic [NOTE_W-1:0] rd_addr;
	logic [POS_W-1:0]  cur;
	logic [POS_W-1:0]  new_val;
	logic              in_voice;
	logic              last_idx;

	// read port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req.note;
		case (state_q)
			S_IDLE: begin
				rd_en   = req.start;
				rd_addr = req.note;
			end
			S_REF: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_SWEEP: begin
				rd_en   = !last_idx;
				rd_addr = idx_q + 1'b1;
			end
			default: begin
				rd_en   = 1'b0;
			end
		endcase
	end

	assign last_idx = (idx_q == NOTE_W'(NUM_NOTES - 1));
	assign cur      = rvld_s1 ? rdata_s1 : '0;

	// new position of the swept entry
	always_comb begin
		new_val = cur;
		if (is_on_q) begin
			if (idx_q == note_q)
				new_val = POS_W'(1);
			else if (cur != '0 && (ref_q == '0 || cur < ref_q))
				new_val = cur + 1'b1;
		end else begin
			if (idx_q == note_q)
				new_val = '0;
			else if (ref_q != '0 && cur > ref_q)
				new_val = cur - 1'b1;
		end
	end

	// swept note already held by a voice
	always_comb begin
		in_voice = 1'b0;
		for (int v = 0; v < MAX_VOICES; v++)
			if (vhas[v] && vnote[v] == idx_q)
				in_voice = 1'b1;
	end

	// memory with registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
		if (state_q == S_SWEEP)
			mem[idx_q] <= new_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (rd_en)
				rvld_s1 <= valid_q[rd_addr];
			if (state_q == S_SWEEP)
				valid_q[idx_q] <= 1'b1;
		end
	end

	// sweep sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heir_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						is_on_q      <= req.is_on;
						note_q       <= req.note;
						heir_found_q <= 1'b0;
						best_q       <= (POS_W+1)'(NUM_NOTES + 1);
						vpos_q       <= '0;
						state_q      <= S_REF;
					end
				end
				S_REF: begin
					ref_q   <= cur;
					idx_q   <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (!is_on_q && new_val != '0 && {1'b0, new_val} < best_q && !in_voice) begin
						best_q       <= {1'b0, new_val};
						heir_q       <= idx_q;
						heir_found_q <= 1'b1;
					end
					for (int v = 0; v < MAX_VOICES; v++)
						if (vhas[v] && vnote[v] == idx_q)
							vpos_q[v] <= new_val;
					if (last_idx)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.done       = (state_q == S_DONE);
	assign res.heir_found = heir_found_q;
	assign res.heir       = heir_q;
	assign vpos           = vpos_q;

endmodule

// ===== sv/poly_voice_allocator_core.sv =====
// Polyphonic voice allocator with note stealing: voice table, sequencer, ports.
//
// Input stream s_*: one request per item: a frame tick, a note-on or a note-off.
// Output stream m_*: a tick yields one request per voice, voices 0..7 in order,
// tlast on voice 7. Note events yield no output, only state changes.
// cfg_we/cfg_data set the number of usable voices (0 acts as 1, above 8 as 8).
// The block takes one item at a time; s_tready is high only when idle.
// A note-off runs a 128-entry read-modify-write sweep of the press-order memory
// (one entry a cycle) before the next ready. A note-on adds one pass over the
// usable voices (one voice a cycle) and a step to start the chosen voice. A tick
// makes 8 output transfers and then advances the voice table; each voice waits
// in the output register until m_tready takes it, so a stalled receiver just
// holds the block busy. Reset clears the voice table and marks every stack entry
// empty at once; the first item may arrive on the cycle after reset.
module poly_voice_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,      // voices_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // cmd[1:0], note[8:2], velocity[15:9]
	output logic        m_tvalid,
	input  logic        m_tready,
	// voice_index[2:0], sounding[3], note_valid[4], voice_note[11:5],
	// voice_event[13:12], release_frames[29:14], zero[31:30]
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import pva_pkg::*;

	typedef enum logic [5:0] {
		T_IDLE  = 6'b000001,
		T_STACK = 6'b000010,
		T_PICK  = 6'b000100,
		T_APPLY = 6'b001000,
		T_EMIT  = 6'b010000,
		T_ADV   = 6'b100000
	} tst_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'b001,
		OP_START   = 3'b010,
		OP_RELEASE = 3'b100
	} vop_t;

	tst_t              state_q;
	logic [3:0]        cfg_q;
	logic              on_q;
	logic [NOTE_W-1:0] note_q;
	logic [VI_W-1:0]   vi_q;

	// voice table
	logic [MAX_VOICES-1:0]          snd_q;
	logic [MAX_VOICES-1:0]          has_q;
	voice_note_arr_t                vnote_q;
	logic [MAX_VOICES-1:0][1:0]     ev_q;
	logic signed [REL_W-1:0]        rel_q [MAX_VOICES];
	logic [MAX_VOICES-1:0]          rte_q;

	// pick pass state
	logic              mfound_q, ifound_q, rfound_q, afound_q;
	logic [VI_W-1:0]   mv_q, iv_q, rv_q, av_q;
	logic signed [REL_W-1:0] rbest_q;
	logic [POS_W-1:0]  abest_q;

	// output register
	logic              oval_q;
	logic [29:0]       odata_q;
	logic              olast_q;

	stk_req_t          stk_req;
	stk_res_t          stk_res;
	pos_arr_t          vpos;

	logic              acc;
	logic [1:0]        in_cmd;
	logic [NOTE_W-1:0] in_note;
	logic [6:0]        in_vel;
	logic [3:0]        lim_m1;
	logic              pick_end;
	logic              m_hs;
	logic [VI_W-1:0]   ld_idx;
	logic [29:0]       ld_data;
	vop_t              vop;
	logic [VI_W-1:0]   vop_idx;
	logic [NOTE_W-1:0] vop_note;
	logic              off_found;
	logic [VI_W-1:0]   off_v;

	assign in_cmd  = s_tdata[1:0];
	assign in_note = s_tdata[8:2];
	assign in_vel  = s_tdata[15:9];
	assign s_tready = (state_q == T_IDLE);
	assign acc     = s_tvalid && s_tready;
	assign m_hs    = oval_q && m_tready;

	// usable voice count, clamped
	always_comb begin
		if (cfg_q == '0)
			lim_m1 = '0;
		else if (cfg_q > 4'(MAX_VOICES))
			lim_m1 = 4'(MAX_VOICES - 1);
		else
			lim_m1 = cfg_q - 1'b1;
	end
	assign pick_end = ({1'b0, vi_q} == lim_m1);

	assign stk_req.start = acc && (in_cmd == CMD_ON || in_cmd == CMD_OFF) &&
	                       (int'(in_note) < NUM_NOTES);
	assign stk_req.is_on = (in_cmd == CMD_ON) && (in_vel != '0);
	assign stk_req.note  = in_note;

	pva_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (stk_req),
		.vnote  (vnote_q),
		.vhas   (has_q),
		.res    (stk_res),
		.vpos   (vpos)
	);

	// voice holding the released note
	always_comb begin
		off_found = 1'b0;
		off_v     = '0;
		for (int v = MAX_VOICES - 1; v >= 0; v--)
			if (has_q[v] && vnote_q[v] == note_q) begin
				off_found = 1'b1;
				off_v     = VI_W'(v);
			end
	end

	// voice table update selection
	always_comb begin
		vop      = OP_NONE;
		vop_idx  = '0;
		vop_note = note_q;
		if (state_q == T_STACK && stk_res.done && !on_q && off_found) begin
			vop_idx = off_v;
			if (stk_res.heir_found) begin
				vop      = OP_START;
				vop_note = stk_res.heir;
			end else begin
				vop = OP_RELEASE;
			end
		end else if (state_q == T_APPLY) begin
			vop = OP_START;
			if (mfound_q)
				vop_idx = mv_q;
			else if (ifound_q)
				vop_idx = iv_q;
			else if (rfound_q)
				vop_idx = rv_q;
			else
				vop_idx = av_q;
		end
	end

	// next result to load into the output register
	assign ld_idx = (state_q == T_IDLE) ? '0 : vi_q + 1'b1;
	always_comb begin
		ld_data = {rel_q[ld_idx], ev_q[ld_idx],
		           has_q[ld_idx] ? vnote_q[ld_idx] : NOTE_W'(0),
		           has_q[ld_idx], snd_q[ld_idx], ld_idx};
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= 4'(MAX_VOICES);
		else if (cfg_we)
			cfg_q <= cfg_data;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			oval_q  <= 1'b0;
			vi_q    <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (acc && in_cmd == CMD_TICK) begin
						odata_q <= ld_data;
						olast_q <= (ld_idx == VI_W'(MAX_VOICES - 1));
						oval_q  <= 1'b1;
						vi_q    <= '0;
						state_q <= T_EMIT;
					end else if (stk_req.start) begin
						on_q    <= stk_req.is_on;
						note_q  <= in_note;
						state_q <= T_STACK;
					end
				end
				T_STACK: begin
					if (stk_res.done) begin
						if (on_q) begin
							vi_q     <= '0;
							mfound_q <= 1'b0;
							ifound_q <= 1'b0;
							rfound_q <= 1'b0;
							afound_q <= 1'b0;
							state_q  <= T_PICK;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				T_PICK: begin
					if (!mfound_q && has_q[vi_q] && vnote_q[vi_q] == note_q) begin
						mfound_q <= 1'b1;
						mv_q     <= vi_q;
					end
					if (!ifound_q && !snd_q[vi_q]) begin
						ifound_q <= 1'b1;
						iv_q     <= vi_q;
					end
					if (rel_q[vi_q] >= 0 && (!rfound_q || rel_q[vi_q] > rbest_q)) begin
						rfound_q <= 1'b1;
						rbest_q  <= rel_q[vi_q];
						rv_q     <= vi_q;
					end
					if (!afound_q || (has_q[vi_q] ? vpos[vi_q] : POS_W'(0)) > abest_q) begin
						afound_q <= 1'b1;
						abest_q  <= has_q[vi_q] ? vpos[vi_q] : POS_W'(0);
						av_q     <= vi_q;
					end
					if (pick_end)
						state_q <= T_APPLY;
					else
						vi_q <= vi_q + 1'b1;
				end
				T_APPLY: begin
					state_q <= T_IDLE;
				end
				T_EMIT: begin
					if (m_hs) begin
						if (olast_q) begin
							oval_q  <= 1'b0;
							state_q <= T_ADV;
						end else begin
							odata_q <= ld_data;
							olast_q <= (ld_idx == VI_W'(MAX_VOICES - 1));
							vi_q    <= ld_idx;
						end
					end
				end
				T_ADV: begin
					state_q <= T_IDLE;
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// voice table: note events and end-of-tick advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snd_q   <= '0;
			has_q   <= '0;
			vnote_q <= '0;
			ev_q    <= '0;
			rte_q   <= '0;
			for (int v = 0; v < MAX_VOICES; v++)
				rel_q[v] <= -16'sd1;
		end else if (state_q == T_ADV) begin
			for (int v = 0; v < MAX_VOICES; v++) begin
				if (ev_q[v] == EV_END) begin
					snd_q[v]   <= 1'b0;
					has_q[v]   <= 1'b0;
					vnote_q[v] <= '0;
					ev_q[v]    <= EV_NONE;
					rel_q[v]   <= -16'sd1;
					rte_q[v]   <= 1'b0;
				end else begin
					ev_q[v] <= rte_q[v] ? EV_END : EV_NONE;
					if (rel_q[v] >= 0 && !rte_q[v]) begin
						if (rel_q[v] != 16'sh7FFF)
							rel_q[v] <= rel_q[v] + 16'sd1;
						rte_q[v] <= 1'b1;
					end
				end
			end
		end else begin
			case (vop)
				OP_START: begin
					snd_q[vop_idx]   <= 1'b1;
					has_q[vop_idx]   <= 1'b1;
					vnote_q[vop_idx] <= vop_note;
					ev_q[vop_idx]    <= EV_START;
					rel_q[vop_idx]   <= -16'sd1;
					rte_q[vop_idx]   <= 1'b0;
				end
				OP_RELEASE: begin
					ev_q[vop_idx]  <= EV_RELEASE;
					rel_q[vop_idx] <= '0;
					rte_q[vop_idx] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata  = {2'b00, odata_q};
	assign m_tlast  = olast_q;

	// checks
	a_last_on_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == VI_W'(MAX_VOICES - 1))))
		else $error("tlast does not match the top voice");

	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("output pending while idle");

	a_done_in_stack: assert property (@(posedge clk) disable iff (!arst_n)
		stk_res.done |-> (state_q == T_STACK))
		else $error("stack finished outside a note event");

	a_next_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(m_hs && !m_tlast) |=> (m_tvalid && m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
		else $error("voice order broken");

endmodule

// ===== dv/tb.sv =====
// Testbench for the polyphonic voice allocator: stream stimulus with a voice-table scoreboard.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the allocator state and the expected voice reports.
class voice_sb;
	logic [7:0]  order [pva_pkg::NUM_NOTES];
	bit          snd [pva_pkg::MAX_VOICES];
	bit          has [pva_pkg::MAX_VOICES];
	logic [6:0]  vnote [pva_pkg::MAX_VOICES];
	logic [1:0]  vev [pva_pkg::MAX_VOICES];
	int          rel [pva_pkg::MAX_VOICES];
	bit          rte [pva_pkg::MAX_VOICES];
	int          nvoices;
	logic [31:0] reports [$];
	int          errors;
	int          checked;

	function new();
		foreach (order[i]) order[i] = 0;
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++) clear_voice(v);
		nvoices = 8;
		errors = 0;
		checked = 0;
	endfunction

	function void clear_voice(int v);
		snd[v] = 0; has[v] = 0; vnote[v] = 0; vev[v] = pva_pkg::EV_NONE;
		rel[v] = -1; rte[v] = 0;
	endfunction

	function void start_voice(int v, logic [6:0] n);
		snd[v] = 1; vev[v] = pva_pkg::EV_START; has[v] = 1; vnote[v] = n;
		rel[v] = -1; rte[v] = 0;
	endfunction

	function void set_voices(logic [3:0] val);
		nvoices = val;
	endfunction

	function int choose_voice(logic [6:0] n);
		int lim, best, pick, oldest, pos;
		lim = nvoices;
		if (lim < 1) lim = 1;
		if (lim > pva_pkg::MAX_VOICES) lim = pva_pkg::MAX_VOICES;
		for (int v = 0; v < lim; v++) if (has[v] && vnote[v] == n) return v;
		for (int v = 0; v < lim; v++) if (!snd[v]) return v;
		best = -1; pick = -1;
		for (int v = 0; v < lim; v++)
			if (rel[v] > best) begin
				best = rel[v]; pick = v;
			end
		if (pick >= 0) return pick;
		// steal by age: a voice with no note ranks as position zero
		oldest = -1; pick = 0;
		for (int v = 0; v < lim; v++) begin
			pos = has[v] ? int'(order[vnote[v]]) : 0;
			if (pos > oldest) begin
				oldest = pos; pick = v;
			end
		end
		return pick;
	endfunction

	function void press(logic [6:0] n);
		logic [7:0] old;
		old = order[n];
		foreach (order[i])
			if (order[i] > 0 && (old == 0 || order[i] < old)) order[i]++;
		order[n] = 1;
		start_voice(choose_voice(n), n);
	endfunction

	function bit held_by_voice(int n);
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++)
			if (has[v] && vnote[v] == n) return 1;
		return 0;
	endfunction

	function void lift(logic [6:0] n);
		logic [7:0] gone;
		int best, heir;
		gone = order[n];
		if (gone > 0) begin
			order[n] = 0;
			foreach (order[i]) if (order[i] > gone) order[i]--;
		end
		best = pva_pkg::NUM_NOTES + 1; heir = -1;
		foreach (order[i])
			if (order[i] > 0 && order[i] < best && !held_by_voice(i)) begin
				best = order[i]; heir = i;
			end
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++)
			if (has[v] && vnote[v] == n) begin
				if (heir < 0) begin
					vev[v] = pva_pkg::EV_RELEASE; rel[v] = 0; rte[v] = 1;
				end else
					start_voice(v, heir[6:0]);
				break;
			end
	endfunction

	function void advance_frame();
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++)
			if (vev[v] == pva_pkg::EV_END) clear_voice(v);
			else vev[v] = pva_pkg::EV_NONE;
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++)
			if (rte[v]) vev[v] = pva_pkg::EV_END;
		for (int v = 0; v < pva_pkg::MAX_VOICES; v++)
			if (rel[v] >= 0 && !rte[v]) begin
				if (rel[v] < 32767) rel[v]++;
				rte[v] = 1;
			end
	endfunction

	// note an accepted request
	function void note_request(logic [15:0] d);
		logic [1:0] cmd;
		logic [6:0] n, vel;
		logic [15:0] rf;
		cmd = d[1:0]; n = d[8:2]; vel = d[15:9];
		if (cmd == pva_pkg::CMD_TICK) begin
			for (int v = 0; v < pva_pkg::MAX_VOICES; v++) begin
				rf = rel[v][15:0];
				reports.push_back({2'b00, rf, vev[v], has[v] ? vnote[v] : 7'd0,
					has[v], snd[v], v[2:0]});
			end
			advance_frame();
		end else if (cmd == pva_pkg::CMD_ON && vel != 0)
			press(n);
		else if (cmd != pva_pkg::CMD_UNUSED)
			lift(n);
	endfunction

	// check one output transfer
	function void check_report(logic [31:0] d, logic lst);
		logic [31:0] e;
		bit el;
		if (reports.size() == 0) begin
			$display("%0t: unexpected voice report %h", $realtime, d);
			errors++;
			return;
		end
		e = reports.pop_front();
		el = (e[2:0] == 3'd7);
		checked++;
		if (e != d || el != lst) begin
			$display("%0t: mismatch exp data %h last %0b, got data %h last %0b",
				$realtime, e, el, d, lst);
			errors++;
		end
	endfunction
endclass

module tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [3:0]  cfg_data = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	voice_sb sb = new();
	int      hold_off = 0;
	int      sent = 0;
	logic [6:0] held [$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	poly_voice_allocator_core u_top (.*);

	// send one request, with a random gap first
	task automatic send(logic [1:0] cmd, logic [6:0] n, logic [6:0] vel);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// step off the edge that took the previous request
		@(posedge clk);
		repeat (gap) @(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {vel, n, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_request({vel, n, cmd});
		s_tvalid <= 0;
		sent++;
	endtask

	// wait until every report has drained, then let a note sweep finish
	task automatic drain();
		while (sb.reports.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_voices(logic [3:0] val);
		drain();
		cfg_we <= 1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_voices(val);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_report(m_tdata, m_tlast);
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 0;
			end else if ($urandom_range(0, 19) == 0)
				m_tready <= 0;
			else if ($urandom_range(0, 2) == 0)
				m_tready <= ($urandom_range(0, 1) == 1);
			else
				m_tready <= 1;
		end
	end

	// random musical traffic: mostly presses and releases of held notes, ticks between
	task automatic random_item();
		int r, k;
		logic [6:0] n;
		r = $urandom_range(0, 99);
		if (r < 30)
			send(pva_pkg::CMD_TICK, 7'($urandom), 7'($urandom));
		else if (r < 65) begin
			n = (held.size() > 0 && $urandom_range(0, 2) == 0) ?
				held[$urandom_range(0, held.size() - 1)] : 7'($urandom);
			send(pva_pkg::CMD_ON, n, 7'($urandom_range(1, 127)));
			held.push_back(n);
		end else if (r < 90 && held.size() > 0) begin
			k = $urandom_range(0, held.size() - 1);
			n = held[k];
			held.delete(k);
			if ($urandom_range(0, 1)) send(pva_pkg::CMD_OFF, n, 7'($urandom));
			else send(pva_pkg::CMD_ON, n, 7'd0);
		end else if (r < 95)
			send(pva_pkg::CMD_OFF, 7'($urandom), 7'($urandom));
		else
			send(pva_pkg::CMD_UNUSED, 7'($urandom), 7'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, all commands, velocity zero, unused command, steals
		send(pva_pkg::CMD_TICK, 7'h7f, 7'h7f);
		send(pva_pkg::CMD_ON, 7'd0, 7'd127);
		send(pva_pkg::CMD_ON, 7'd127, 7'd1);
		send(pva_pkg::CMD_ON, 7'd60, 7'd64);
		send(pva_pkg::CMD_ON, 7'd0, 7'd30);
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		send(pva_pkg::CMD_OFF, 7'd5, 7'd0);
		send(pva_pkg::CMD_OFF, 7'd127, 7'd127);
		send(pva_pkg::CMD_ON, 7'd60, 7'd0);
		send(pva_pkg::CMD_UNUSED, 7'h55, 7'h2a);
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		write_voices(4'd2);
		send(pva_pkg::CMD_ON, 7'd10, 7'd1);
		send(pva_pkg::CMD_ON, 7'd11, 7'd1);
		send(pva_pkg::CMD_ON, 7'd12, 7'd1);
		send(pva_pkg::CMD_ON, 7'd13, 7'd1);
		send(pva_pkg::CMD_OFF, 7'd13, 7'd0);
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		send(pva_pkg::CMD_ON, 7'd14, 7'd1);
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		send(pva_pkg::CMD_ON, 7'd15, 7'd1);
		for (int i = 10; i < 16; i++) send(pva_pkg::CMD_OFF, i[6:0], 7'd0);
		// long receiver hold-off while ticks keep coming
		hold_off = 400;
		repeat (4) send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		// random phases across voice counts
		write_voices(4'd0);  repeat (10) random_item();
		write_voices(4'd1);  repeat (10) random_item();
		write_voices(4'd15); repeat (15) random_item();
		write_voices(4'd3);  repeat (15) random_item();
		write_voices(4'd8);  repeat (20) random_item();
		send(pva_pkg::CMD_TICK, 7'd0, 7'd0);
		drain();
		$display("Sent %0d requests over voice counts 0..15; checked %0d voice reports.",
			sent, sb.checked);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#8ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
